@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tdp_pkg.sv @@
// Shared types and constants of the trial-division prime test.
package tdp_pkg;
	localparam int VALUE_BITS_DEF = 32;
	localparam int CAND_BITS      = 32;
	localparam int FIRST_DIVISOR  = 5;
	localparam int WHEEL_STEP     = 6;
	localparam int PAIR_OFFSET    = 2;
	localparam int SMALL_DIVISOR  = 3;
	localparam int FIRST_COMPOSITE = 4;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} tdp_rem_status_t;
endpackage

@@ hdl/trial_division_prime_test_top.sv @@
// Top level of the trial-division prime test with its sequencer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  request  | in_valid / in_ready   | candidate  (32 bits, unsigned)
//  result   | out_valid / out_ready | prime_flag (1 bit)
//
// Sequence: numbers below 4 and even numbers go straight to the result;
//   otherwise a remainder by 3 and then, per 6k+/-1 divisor pair, a bound
//   check plus two remainders. The worst case grows with about sqrt(n)/6
//   pairs, set by the single bit-serial remainder unit.
// Reset: arst_n clears the sequencer and the result slot; no clearing pass.
// Stalls: in_ready is high only while idle; a held result blocks the next
//   request from finishing, not from being accepted.
`include "assert_macros.svh"
module trial_division_prime_test_top #(
	parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tdp_pkg::CAND_BITS-1:0] candidate,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         prime_flag
);
	import tdp_pkg::*;

	localparam int IN_W = (VALUE_BITS < CAND_BITS) ? VALUE_BITS : CAND_BITS;
	// d*d fits twice the value width
	localparam int SQ_W = 2 * VALUE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV3,
		ST_BOUND,
		ST_DIV_LO,
		ST_DIV_HI,
		ST_RESULT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] n_q;       // number under test
	logic [VALUE_BITS-1:0] d_q;       // lower divisor of the pair, 6k-1
	logic [SQ_W-1:0]       sq_q;      // d_q squared
	logic [VALUE_BITS-1:0] rdiv_q;    // divisor handed to the remainder unit
	logic                  rstart_q;
	logic                  res_q;
	logic                  out_valid_q;
	logic                  prime_q;

	logic [VALUE_BITS-1:0] n_in;
	logic [SQ_W-1:0]       sq_inc;
	logic                  accept;
	logic                  slot_free;
	tdp_rem_status_t       rstat;

	// only the low VALUE_BITS of the request are tested
	assign n_in      = VALUE_BITS'(candidate[IN_W-1:0]);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	// (d+6)^2 - d^2 = 12d + 36
	assign sq_inc = SQ_W'(d_q) * SQ_W'(2 * WHEEL_STEP) + SQ_W'(WHEEL_STEP * WHEEL_STEP);

	tdp_rem_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rstart_q),
		.dividend(n_q),
		.divisor (rdiv_q),
		.status  (rstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rstart_q    <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= 1'b0;
			prime_q     <= 1'b0;
			d_q         <= '0;
			sq_q        <= '0;
			n_q         <= '0;
			rdiv_q      <= '0;
		end else begin
			rstart_q <= 1'b0;
			// a verdict moving in from ST_RESULT refills the slot itself
			if (out_valid_q && out_ready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q  <= n_in;
						d_q  <= VALUE_BITS'(FIRST_DIVISOR);
						sq_q <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
						if (n_in < VALUE_BITS'(PAIR_OFFSET)) begin
							res_q   <= 1'b0;
							state_q <= ST_RESULT;
						end else if (n_in < VALUE_BITS'(FIRST_COMPOSITE)) begin
							res_q   <= 1'b1;
							state_q <= ST_RESULT;
						end else if (!n_in[0]) begin
							res_q   <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							rdiv_q   <= VALUE_BITS'(SMALL_DIVISOR);
							rstart_q <= 1'b1;
							state_q  <= ST_DIV3;
						end
					end
				end
				ST_DIV3: begin
					if (rstat.done) begin
						if (rstat.zero) begin
							res_q   <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_BOUND;
						end
					end
				end
				ST_BOUND: begin
					if (sq_q > SQ_W'(n_q)) begin
						res_q   <= 1'b1;
						state_q <= ST_RESULT;
					end else begin
						rdiv_q   <= d_q;
						rstart_q <= 1'b1;
						state_q  <= ST_DIV_LO;
					end
				end
				ST_DIV_LO: begin
					if (rstat.done) begin
						if (rstat.zero) begin
							res_q   <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							rdiv_q   <= d_q + VALUE_BITS'(PAIR_OFFSET);
							rstart_q <= 1'b1;
							state_q  <= ST_DIV_HI;
						end
					end
				end
				ST_DIV_HI: begin
					if (rstat.done) begin
						if (rstat.zero) begin
							res_q   <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							d_q     <= d_q + VALUE_BITS'(WHEEL_STEP);
							sq_q    <= sq_q + sq_inc;
							state_q <= ST_BOUND;
						end
					end
				end
				ST_RESULT: begin
					// wait for the output slot to empty
					if (slot_free) begin
						out_valid_q <= 1'b1;
						prime_q     <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign prime_flag = prime_q;

	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`ASSERT_IMPLIES(a_idle_unit_quiet, clk, arst_n, state_q == ST_IDLE, !rstat.busy)
	`ASSERT_IMPLIES(a_start_unit_free, clk, arst_n, rstart_q, !rstat.busy && !rstat.done)
endmodule

@@ hdl/tdp_rem_unit.sv @@
// Restoring remainder unit, one quotient bit per cycle.
`include "assert_macros.svh"
module tdp_rem_unit #(
	parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_BITS-1:0]   dividend,
	input  logic [VALUE_BITS-1:0]   divisor,
	output tdp_pkg::tdp_rem_status_t status
);
	import tdp_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS+1:0] diff;
	logic [VALUE_BITS-1:0] rem_next;

	assign shifted  = {rem_q, dvd_q[VALUE_BITS-1]};
	assign diff     = {1'b0, shifted} - {2'b00, div_q};
	// borrow set: keep the shifted partial remainder
	assign rem_next = diff[VALUE_BITS+1] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.zero = (rem_q == '0);

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy_q, busy_q)
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done_q, !busy_q)
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
endmodule

@@ sim/tdp_prime_checker.sv @@
// Prime test checker: predicts each verdict from the request channel and compares results.
module tdp_prime_checker #(
	parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [tdp_pkg::CAND_BITS-1:0] candidate,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          prime_flag,
	output int                            fail_count,
	output int                            flags_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          REPORT_LIMIT = 10;
	localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);

	typedef struct {
		logic [tdp_pkg::CAND_BITS-1:0] number;
		logic                          flag;
	} verdict_t;

	verdict_t verdict_q[$];

	// 6k+/-1 wheel; bound kept as d <= n/d so it never overflows
	function automatic logic wheel_prime(input logic [63:0] n);
		logic [63:0] d;
		if (n < 2)
			return 1'b0;
		if (n < tdp_pkg::FIRST_COMPOSITE)
			return 1'b1;
		if (n % 2 == 0 || n % tdp_pkg::SMALL_DIVISOR == 0)
			return 1'b0;
		for (d = tdp_pkg::FIRST_DIVISOR; d <= n / d; d += tdp_pkg::WHEEL_STEP) begin
			if (n % d == 0 || n % (d + tdp_pkg::PAIR_OFFSET) == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t    fresh;
		verdict_t    head;
		logic [63:0] wide;
		if (!arst_n) begin
			verdict_q.delete();
			fail_count    = 0;
			flags_pending = 0;
		end else begin
			if (in_valid && in_ready) begin
				wide         = candidate;
				fresh.number = candidate;
				fresh.flag   = wheel_prime(wide & VALUE_MASK);
				verdict_q.push_back(fresh);
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("unexpected result: prime_flag=%0b", prime_flag);
					fail_count++;
				end else begin
					head = verdict_q.pop_front();
					if (prime_flag !== head.flag) begin
						if (fail_count < REPORT_LIMIT)
							$display("mismatch for %0d: prime_flag expected %0b, got %0b",
								head.number, head.flag, prime_flag);
						fail_count++;
					end
				end
			end
			flags_pending = verdict_q.size();
		end
	end
endmodule

@@ sim/tb.sv @@
// Testbench top for the prime test: request stimulus, result back-pressure and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS   = tdp_pkg::VALUE_BITS_DEF;
	localparam int RANDOM_COUNT = 100;
	// The long hold-off starts once this many results are in, well into the
	// random part where requests are cheap and keep queuing up.
	localparam int STALL_AT     = 40;
	// Covers two of the slowest random requests, so the
	// slot and the sequencer are both full before the hold-off ends.
	localparam int STALL_CYCLES = 20_000;
	// Largest 32-bit prime walks ~10.9k divisor pairs with no handshake at
	// all; the limit allows several times that long a run.
	localparam int QUIET_LIMIT  = 3_000_000;
	localparam int TAIL_CYCLES  = 200;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic [tdp_pkg::CAND_BITS-1:0] candidate = '0;
	logic                          out_ready = 1'b0;
	logic                          in_ready;
	logic                          out_valid;
	logic                          prime_flag;

	int fail_count;
	int flags_pending;
	int results_seen = 0;
	int quiet_cycles = 0;

	// Idle pattern state: each side runs in stretches, some of them gap-free.
	int send_run  = 0;
	bit send_calm = 1'b0;
	int take_run  = 0;
	bit take_calm = 1'b0;

	// Hand-picked requests: zero and one, the small primes, the first
	// composites, exact squares of wheel divisors (the loop bound hit on the
	// nose, on both the 6k-1 and 6k+1 side), field extremes and the largest
	// 32-bit prime, which is the slowest request the block can see.
	logic [tdp_pkg::CAND_BITS-1:0] directed_numbers [0:22] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
		32'd23, 32'd25, 32'd35, 32'd49, 32'd97, 32'd121, 32'd169, 32'd289,
		32'd63001, 32'd65537, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
		32'd4294967291
	};

	trial_division_prime_test_top #(
		.VALUE_BITS (VALUE_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.candidate  (candidate),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_flag (prime_flag)
	);

	tdp_prime_checker #(
		.VALUE_BITS (VALUE_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.candidate     (candidate),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.prime_flag    (prime_flag),
		.fail_count    (fail_count),
		.flags_pending (flags_pending)
	);

	initial forever #5 clk = ~clk;

	// Gap before the next request or result: a random draw, except during a
	// calm stretch where the side runs flat out.
	function automatic int idle_gap(inout int run, inout bit calm);
		if (run == 0) begin
			run  = $urandom_range(4, 16);
			calm = ($urandom_range(0, 2) == 0);
		end
		run--;
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// Random candidates, weighted so the run stays short: a 32-bit prime is
	// the slowest kind of request, so full-width values always carry a small
	// factor (2, 3, or a 6k+/-1 divisor below ~245) and primes come from
	// the narrower ranges only.
	function automatic logic [tdp_pkg::CAND_BITS-1:0] random_candidate();
		int unsigned pick;
		int unsigned factor;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return $urandom_range(0, 300);
		if (pick < 60)
			return $urandom_range(0, 65535);
		if (pick < 70)
			return $urandom_range(0, 1 << 18);
		if (pick < 78)
			return {$urandom} & ~32'd1;
		if (pick < 85)
			return $urandom_range(0, 32'h5555_5555) * 3;
		factor = $urandom_range(1, 40) * tdp_pkg::WHEEL_STEP + ($urandom_range(0, 1) ? 1 : -1);
		return factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
	endfunction

	// One request: optional idle gap, then valid held with a steady payload
	// until the block takes it. A zero gap keeps valid high across requests.
	task automatic offer(input logic [tdp_pkg::CAND_BITS-1:0] value);
		int gap;
		gap = idle_gap(send_run, send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// Request side and verdict.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_numbers[i])
			offer(directed_numbers[i]);
		repeat (RANDOM_COUNT)
			offer(random_candidate());
		in_valid <= 1'b0;
		// let the checker register the last request before polling
		@(posedge clk);
		while (flags_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && flags_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off so a result
	// sits in the slot, the next request is taken and finished behind it,
	// and in_ready stays low while the sender keeps offering.
	initial begin
		int gap;
		forever begin
			gap = idle_gap(take_run, take_calm);
			if (results_seen == STALL_AT)
				gap = STALL_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
		end
	end

	// Watchdog: any handshake on either channel resets the quiet count.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end
endmodule
